// ===== hdl/order_message_field_extractor_assert.svh =====
// Assertion macros for the order message field extractor.
// Used by the port checker; needs clk_i and rst_ni in scope.
`ifndef ORDER_MESSAGE_FIELD_EXTRACTOR_ASSERT_SVH
`define ORDER_MESSAGE_FIELD_EXTRACTOR_ASSERT_SVH

// checked outside reset only
`define OME_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define OME_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hdl/ome_pkg.sv =====
// Shared types and constants of the order message field extractor.
// No dependencies.
package ome_pkg;

  localparam int COUNT_WIDTH   = 32;
  localparam int MAX_MSG_BYTES = 64;
  localparam int POS_W         = $clog2(MAX_MSG_BYTES);
  localparam int NUM_TYPES     = 7;
  localparam int SLOT_W        = 3;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

  // request codes
  localparam logic [1:0] REQ_BYTE  = 2'd0;
  localparam logic [1:0] REQ_EMPTY = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // result status
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;

  // message kinds
  localparam logic [2:0] KIND_ADD     = 3'd0;
  localparam logic [2:0] KIND_EXECUTE = 3'd1;
  localparam logic [2:0] KIND_CANCEL  = 3'd2;
  localparam logic [2:0] KIND_DELETE  = 3'd3;
  localparam logic [2:0] KIND_REPLACE = 3'd4;

  // type characters
  localparam logic [7:0] CH_B = "B";
  localparam logic [7:0] CH_F = "F";
  localparam logic [7:0] CH_A = "A";
  localparam logic [7:0] CH_C = "C";
  localparam logic [7:0] CH_E = "E";
  localparam logic [7:0] CH_X = "X";
  localparam logic [7:0] CH_D = "D";
  localparam logic [7:0] CH_U = "U";

  // counter slots, one per known type character
  localparam logic [SLOT_W-1:0] SLOT_F    = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_A    = 3'd1;
  localparam logic [SLOT_W-1:0] SLOT_C    = 3'd2;
  localparam logic [SLOT_W-1:0] SLOT_E    = 3'd3;
  localparam logic [SLOT_W-1:0] SLOT_X    = 3'd4;
  localparam logic [SLOT_W-1:0] SLOT_D    = 3'd5;
  localparam logic [SLOT_W-1:0] SLOT_U    = 3'd6;
  localparam logic [SLOT_W-1:0] SLOT_NONE = 3'd7;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_EMPTY = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] data_byte;
    logic       end_of_msg;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  kind;
    logic [15:0] locate;
    logic [63:0] order_id;
    logic [63:0] new_order_id;
    logic [31:0] quantity;
    logic [31:0] price;
    logic        is_sell;
    logic [31:0] count_value;
  } result_t;

  // classified beat passed from front to back
  typedef struct packed {
    op_e               op;
    logic [SLOT_W-1:0] slot;
    logic [POS_W-1:0]  pos;
    logic [7:0]        data;
    logic              last;
  } beat_t;

endpackage

// ===== hdl/ome_front.sv =====
// Front end: accepts input beats, tracks byte position and message type,
// and classifies each beat for the back end. Depends on ome_pkg.
module ome_front import ome_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  input  in_beat_t in_beat_i,
  input  logic     q_full_i,
  output logic     q_push_o,
  output beat_t    q_beat_o
);

  logic [POS_W-1:0]  pos_q, pos_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic              accept;
  logic [SLOT_W-1:0] byte_slot;

  function automatic logic [SLOT_W-1:0] type_slot(logic [7:0] t);
    logic [SLOT_W-1:0] s;
    unique case (t)
      CH_F:    s = SLOT_F;
      CH_A:    s = SLOT_A;
      CH_C:    s = SLOT_C;
      CH_E:    s = SLOT_E;
      CH_X:    s = SLOT_X;
      CH_D:    s = SLOT_D;
      CH_U:    s = SLOT_U;
      default: s = SLOT_NONE;
    endcase
    return s;
  endfunction

  assign accept    = push && !q_full_i;
  // byte 0 carries the type; later bytes use the stored one
  assign byte_slot = (pos_q == '0) ? type_slot(in_beat_i.data_byte) : slot_q;

  always_comb begin
    pos_d         = pos_q;
    slot_d        = slot_q;
    q_push_o      = 1'b0;
    q_beat_o.op   = OP_BYTE;
    q_beat_o.slot = byte_slot;
    q_beat_o.pos  = pos_q;
    q_beat_o.data = in_beat_i.data_byte;
    q_beat_o.last = in_beat_i.end_of_msg;
    unique case (in_beat_i.req_type)
      REQ_BYTE: begin
        q_push_o = accept;
        if (accept) begin
          slot_d = byte_slot;
          if (in_beat_i.end_of_msg) begin
            pos_d = '0;
          end else if (pos_q != POS_W'(MAX_MSG_BYTES - 1)) begin
            pos_d = pos_q + 1'b1;
          end
        end
      end
      REQ_EMPTY: begin
        q_push_o    = accept;
        q_beat_o.op = OP_EMPTY;
        if (accept) begin
          pos_d  = '0;
          slot_d = SLOT_NONE;
        end
      end
      REQ_READ: begin
        q_push_o      = accept;
        q_beat_o.op   = OP_READ;
        q_beat_o.slot = type_slot(in_beat_i.data_byte);
      end
      default: ;  // unused code, dropped
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      slot_q <= SLOT_NONE;
    end else begin
      pos_q  <= pos_d;
      slot_q <= slot_d;
    end
  end

endmodule

// ===== hdl/ome_queue.sv =====
// Short queue of classified beats between front and back end.
// Depends on ome_pkg.
module ome_queue import ome_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  beat_t beat_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output beat_t head_o
);

  beat_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QPTR_W:0]   cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= beat_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (QPTR_W + 1)'(do_push) - (QPTR_W + 1)'(do_pop);
    end
  end

endmodule

// ===== hdl/ome_back.sv =====
// Back end: gathers message fields, keeps the counters and holds results
// in a two-entry output queue. Depends on ome_pkg.
module ome_back import ome_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    q_empty_i,
  input  beat_t   q_head_i,
  output logic    q_pop_o,
  output logic    empty,
  input  logic    pop,
  output result_t result_o
);

  logic [15:0] loc_q, loc_d;
  logic [63:0] ord_q, ord_d;
  logic [63:0] nid_q, nid_d;
  logic [31:0] qty_q, qty_d;
  logic [31:0] prc_q, prc_d;
  logic [7:0]  side_q, side_d;
  count_t      total_q, total_d;
  count_t      cnt_q [NUM_TYPES];
  count_t      cnt_d [NUM_TYPES];

  result_t     oq_q [2];
  logic        oq_head_q;
  logic [1:0]  oq_cnt_q;
  logic        oq_pop;
  logic        oq_wr_idx;

  result_t     res;
  logic        res_vld;
  logic        take;
  logic        known;
  logic [2:0]  kind;

  function automatic logic [63:0] gather(logic [63:0] acc, logic [POS_W-1:0] pos,
                                         int start, int len, logic [7:0] b);
    int p;
    logic [63:0] r;
    p = int'(pos);
    r = acc;
    if (p >= start && p < start + len) begin
      r = acc | (64'(b) << (8 * (start + len - 1 - p)));
    end
    return r;
  endfunction

  function automatic logic [2:0] kind_of(logic [SLOT_W-1:0] s);
    logic [2:0] k;
    unique case (s)
      SLOT_F, SLOT_A: k = KIND_ADD;
      SLOT_C, SLOT_E: k = KIND_EXECUTE;
      SLOT_X:         k = KIND_CANCEL;
      SLOT_D:         k = KIND_DELETE;
      SLOT_U:         k = KIND_REPLACE;
      default:        k = KIND_ADD;
    endcase
    return k;
  endfunction

  function automatic count_t bump(count_t c);
    return (c != '1) ? c + 1'b1 : c;
  endfunction

  function automatic logic [31:0] count_low(count_t c);
    logic [63:0] w;
    w = 64'(c);
    return w[31:0];
  endfunction

  assign take      = !q_empty_i && (oq_cnt_q != 2'd2);
  assign q_pop_o   = take;
  assign known     = (q_head_i.slot != SLOT_NONE);
  assign kind      = kind_of(q_head_i.slot);
  assign empty     = (oq_cnt_q == 2'd0);
  assign result_o  = oq_q[oq_head_q];
  assign oq_pop    = pop && !empty;
  assign oq_wr_idx = oq_head_q ^ oq_cnt_q[0];

  always_comb begin
    loc_d   = loc_q;
    ord_d   = ord_q;
    nid_d   = nid_q;
    qty_d   = qty_q;
    prc_d   = prc_q;
    side_d  = side_q;
    total_d = total_q;
    cnt_d   = cnt_q;
    res     = '0;
    res_vld = 1'b0;
    if (take) begin
      unique case (q_head_i.op)
        OP_EMPTY: begin
          res_vld         = 1'b1;
          res.status      = ST_EMPTY;
          res.count_value = count_low(total_q);
          loc_d  = '0;
          ord_d  = '0;
          nid_d  = '0;
          qty_d  = '0;
          prc_d  = '0;
          side_d = '0;
        end
        OP_READ: begin
          res_vld         = 1'b1;
          res.status      = ST_OK;
          res.count_value = known ? count_low(cnt_q[q_head_i.slot]) : 32'd0;
        end
        OP_BYTE: begin
          if (known) begin
            loc_d = 16'(gather(64'(loc_q), q_head_i.pos, 1, 2, q_head_i.data));
            ord_d = gather(ord_q, q_head_i.pos, 11, 8, q_head_i.data);
            case (kind)
              KIND_ADD: begin
                if (q_head_i.pos == POS_W'(19)) begin
                  side_d = q_head_i.data;
                end
                qty_d = 32'(gather(64'(qty_q), q_head_i.pos, 20, 4, q_head_i.data));
                prc_d = 32'(gather(64'(prc_q), q_head_i.pos, 32, 4, q_head_i.data));
              end
              KIND_EXECUTE, KIND_CANCEL: begin
                qty_d = 32'(gather(64'(qty_q), q_head_i.pos, 19, 4, q_head_i.data));
              end
              KIND_REPLACE: begin
                nid_d = gather(nid_q, q_head_i.pos, 19, 8, q_head_i.data);
                qty_d = 32'(gather(64'(qty_q), q_head_i.pos, 27, 4, q_head_i.data));
                prc_d = 32'(gather(64'(prc_q), q_head_i.pos, 31, 4, q_head_i.data));
              end
              default: ;
            endcase
          end
          if (q_head_i.last) begin
            res_vld = 1'b1;
            if (!known) begin
              res.status      = ST_UNKNOWN;
              res.count_value = count_low(total_q);
            end else begin
              total_d                = bump(total_q);
              cnt_d[q_head_i.slot]   = bump(cnt_q[q_head_i.slot]);
              res.status             = ST_OK;
              res.kind               = kind;
              res.locate             = loc_d;
              res.order_id           = ord_d;
              res.new_order_id       = nid_d;
              res.quantity           = qty_d;
              res.price              = prc_d;
              res.is_sell            = (kind == KIND_ADD) && (side_d != CH_B);
              res.count_value        = count_low(total_d);
            end
            // message done, start the next one from zero
            loc_d  = '0;
            ord_d  = '0;
            nid_d  = '0;
            qty_d  = '0;
            prc_d  = '0;
            side_d = '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loc_q   <= '0;
      ord_q   <= '0;
      nid_q   <= '0;
      qty_q   <= '0;
      prc_q   <= '0;
      side_q  <= '0;
      total_q <= '0;
      for (int i = 0; i < NUM_TYPES; i++) begin
        cnt_q[i] <= '0;
      end
      oq_head_q <= 1'b0;
      oq_cnt_q  <= 2'd0;
    end else begin
      loc_q   <= loc_d;
      ord_q   <= ord_d;
      nid_q   <= nid_d;
      qty_q   <= qty_d;
      prc_q   <= prc_d;
      side_q  <= side_d;
      total_q <= total_d;
      cnt_q   <= cnt_d;
      if (oq_pop) begin
        oq_head_q <= ~oq_head_q;
      end
      oq_cnt_q <= oq_cnt_q + 2'(res_vld) - 2'(oq_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_vld) begin
      oq_q[oq_wr_idx] <= res;
    end
  end

endmodule

// ===== hdl/order_message_field_extractor.sv =====
// Top level of the order message field extractor.
// Depends on ome_pkg, ome_front, ome_queue and ome_back.
//
// Takes one message byte (or an empty-message or count-read request) per
// clock and gives one result per finished message, empty message or count
// read. Throughput is one beat per cycle as long as results are popped. The
// front end classifies each accepted beat into a four-beat queue; the back
// end gathers fields and counts, then registers each result into a two-entry
// output queue that drives the result ports. full rises only once the
// four-beat queue fills, i.e. after the result side stalls.
module order_message_field_extractor import ome_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  output logic     full,
  input  in_beat_t in_beat_i,
  output logic     empty,
  input  logic     pop,
  output result_t  result_o
);

  logic  q_push, q_full, q_pop, q_empty;
  beat_t q_beat, q_head;

  assign full = q_full;

  ome_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .in_beat_i (in_beat_i),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_beat_o  (q_beat)
  );

  ome_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .beat_i  (q_beat),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  ome_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_head_i  (q_head),
    .q_pop_o   (q_pop),
    .empty     (empty),
    .pop       (pop),
    .result_o  (result_o)
  );

endmodule

// ===== hdl/ome_checker.sv =====
// Port-level checks for the order message field extractor, bound to the top.
// Depends on ome_pkg and order_message_field_extractor_assert.svh.
`include "order_message_field_extractor_assert.svh"

module ome_checker import ome_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     push,
  input logic     full,
  input in_beat_t in_beat_i,
  input logic     empty,
  input logic     pop,
  input result_t  result_o
);

  `OME_ASSERT_RST(a_reset_idle, !rst_ni |=> empty && !full, "not idle after reset")
  `OME_ASSERT(a_result_hold, !empty && !pop |=> !empty && $stable(result_o), "result beat changed while stalled")
  `OME_ASSERT(a_empty_zero, !empty && result_o.status == ST_EMPTY |-> result_o.order_id == 64'd0 && result_o.quantity == 32'd0 && result_o.price == 32'd0 && result_o.locate == 16'd0, "empty message with fields")
  `OME_ASSERT(a_sell_add, !empty && result_o.is_sell |-> result_o.kind == KIND_ADD && result_o.status == ST_OK, "side set on non-add")
  `OME_ASSERT(a_new_id_replace, !empty && result_o.new_order_id != 64'd0 |-> result_o.kind == KIND_REPLACE, "new order id on non-replace")

endmodule

bind order_message_field_extractor ome_checker u_ome_checker (.*);

// ===== test/tb_order_message_field_extractor.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for order_message_field_extractor: a short table of
// directed beats with expected results, then random order messages checked by
// a beat-level field decoder. Depends on ome_pkg and the extractor RTL only.
module tb_order_message_field_extractor;
  import ome_pkg::*;

  localparam logic [1:0] REQ_UNUSED  = 2'd3;
  localparam int         RAND_BEATS  = 850;
  localparam int         MIN_RESULTS = 48;
  localparam int         LONG_STALL  = 400;
  localparam int         CYCLE_LIMIT = 300000;
  localparam int         DIR_ROWS    = 24;
  localparam logic [7:0] TYPE_CODES [7] = '{CH_F, CH_A, CH_C, CH_E, CH_X, CH_D, CH_U};

  typedef struct {
    in_beat_t beat;
    bit       chk;
    result_t  want;
  } dir_row_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     push = 1'b0;
  logic     full;
  in_beat_t in_beat_i = '0;
  logic     empty;
  logic     pop = 1'b0;
  result_t  result_o;

  order_message_field_extractor uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .in_beat_i(in_beat_i),
    .empty    (empty),
    .pop      (pop),
    .result_o (result_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // decoder state, mirrors the block after reset
  logic [POS_W-1:0] at_pos = '0;
  logic [7:0]       cur_type = '0;
  logic [63:0]      acc_oid = '0, acc_noid = '0, acc_qty = '0, acc_px = '0;
  logic [15:0]      acc_loc = '0;
  logic [7:0]       acc_side = '0;
  count_t           total_cnt = '0;
  count_t           type_cnt [NUM_TYPES] = '{default: '0};

  result_t  results_due [$];
  int       mismatches = 0;
  int       beats_sent = 0;
  int       results_made = 0;
  int       cycles = 0;
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  bit       hold_go = 1'b0;
  bit       rx_hold = 1'b0;
  bit       note_chk = 1'b0;
  result_t  note_want = '0;
  result_t  mon_r;
  dir_row_t dir_tab [DIR_ROWS];

  function automatic logic [SLOT_W-1:0] slot_of(logic [7:0] t);
    case (t)
      CH_F: return SLOT_F;
      CH_A: return SLOT_A;
      CH_C: return SLOT_C;
      CH_E: return SLOT_E;
      CH_X: return SLOT_X;
      CH_D: return SLOT_D;
      CH_U: return SLOT_U;
      default: return SLOT_NONE;
    endcase
  endfunction

  function automatic logic [2:0] kind_of_slot(logic [SLOT_W-1:0] s);
    case (s)
      SLOT_C, SLOT_E: return KIND_EXECUTE;
      SLOT_X: return KIND_CANCEL;
      SLOT_D: return KIND_DELETE;
      SLOT_U: return KIND_REPLACE;
      default: return KIND_ADD;
    endcase
  endfunction

  // big-endian field capture at a fixed byte offset
  function automatic logic [63:0] gather_at(logic [63:0] acc, int unsigned p,
                                            int unsigned first, int unsigned nbytes,
                                            logic [7:0] b);
    if (p >= first && p < first + nbytes)
      return acc | (64'(b) << (8 * (first + nbytes - 1 - p)));
    return acc;
  endfunction

  function automatic count_t sat_inc(count_t c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  function automatic void drop_message();
    at_pos   = '0;
    cur_type = '0;
    acc_oid  = '0;
    acc_noid = '0;
    acc_qty  = '0;
    acc_px   = '0;
    acc_loc  = '0;
    acc_side = '0;
  endfunction

  // advances the decoder by one accepted beat; returns 1 when a result is due
  function automatic bit decode_beat(input in_beat_t bt, output result_t r);
    logic [SLOT_W-1:0] s;
    logic [2:0]        k;
    int unsigned       p;
    logic [7:0]        b;
    r = '0;
    b = bt.data_byte;
    case (bt.req_type)
      REQ_EMPTY: begin
        drop_message();
        r.status      = ST_EMPTY;
        r.count_value = total_cnt;
        return 1'b1;
      end
      REQ_READ: begin
        s = slot_of(b);
        r.count_value = (s == SLOT_NONE) ? '0 : type_cnt[s];
        return 1'b1;
      end
      REQ_BYTE: begin
        p = at_pos;
        if (p == 0) cur_type = b;
        s = slot_of(cur_type);
        k = kind_of_slot(s);
        if (s != SLOT_NONE) begin
          acc_loc = 16'(gather_at(64'(acc_loc), p, 1, 2, b));
          acc_oid = gather_at(acc_oid, p, 11, 8, b);
          case (k)
            KIND_ADD: begin
              if (p == 19) acc_side = b;
              acc_qty = gather_at(acc_qty, p, 20, 4, b);
              acc_px  = gather_at(acc_px, p, 32, 4, b);
            end
            KIND_EXECUTE, KIND_CANCEL: acc_qty = gather_at(acc_qty, p, 19, 4, b);
            KIND_REPLACE: begin
              acc_noid = gather_at(acc_noid, p, 19, 8, b);
              acc_qty  = gather_at(acc_qty, p, 27, 4, b);
              acc_px   = gather_at(acc_px, p, 31, 4, b);
            end
            default: ;
          endcase
        end
        if (!bt.end_of_msg) begin
          if (p < MAX_MSG_BYTES - 1) at_pos = at_pos + 1'b1;
          return 1'b0;
        end
        if (s == SLOT_NONE) begin
          r.status = ST_UNKNOWN;
        end else begin
          total_cnt   = sat_inc(total_cnt);
          type_cnt[s] = sat_inc(type_cnt[s]);
          r.kind         = k;
          r.locate       = acc_loc;
          r.order_id     = acc_oid;
          r.new_order_id = acc_noid;
          r.quantity     = acc_qty[31:0];
          r.price        = acc_px[31:0];
          r.is_sell      = (k == KIND_ADD) && (acc_side != CH_B);
        end
        r.count_value = total_cnt;
        drop_message();
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic string fmt(result_t r);
    return $sformatf("st=%0d kind=%0d loc=%h oid=%h noid=%h qty=%h px=%h sell=%0d cnt=%0d",
                     r.status, r.kind, r.locate, r.order_id, r.new_order_id,
                     r.quantity, r.price, r.is_sell, r.count_value);
  endfunction

  function automatic in_beat_t beat(logic [1:0] rq, logic [7:0] b, logic e);
    in_beat_t bt;
    bt.req_type   = rq;
    bt.data_byte  = b;
    bt.end_of_msg = e;
    return bt;
  endfunction

  function automatic result_t res(logic [1:0] st, logic [2:0] kd, logic [15:0] loc,
                                  logic sell, logic [31:0] cnt);
    result_t r;
    r = '0;
    r.status      = st;
    r.kind        = kd;
    r.locate      = loc;
    r.is_sell     = sell;
    r.count_value = cnt;
    return r;
  endfunction

  // accept side and result side, both sampled at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        if (decode_beat(in_beat_i, mon_r)) begin
          if (note_chk) mon_r = note_want;
          results_due.push_back(mon_r);
          results_made++;
        end
      end
      if (pop && !empty) begin
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result: %s", fmt(result_o));
        end else begin
          mon_r = results_due.pop_front();
          if (result_o.status !== mon_r.status || result_o.kind !== mon_r.kind ||
              result_o.locate !== mon_r.locate || result_o.order_id !== mon_r.order_id ||
              result_o.new_order_id !== mon_r.new_order_id ||
              result_o.quantity !== mon_r.quantity || result_o.price !== mon_r.price ||
              result_o.is_sell !== mon_r.is_sell ||
              result_o.count_value !== mon_r.count_value) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch\n  exp %s\n  got %s", fmt(mon_r), fmt(result_o));
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_order_message_field_extractor: FAIL");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    pop <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // long receiver hold-off so the block backs up and raises full
  initial begin
    wait (hold_go);
    @(posedge clk_i);
    rx_hold = 1'b1;
    repeat (LONG_STALL) @(posedge clk_i);
    rx_hold = 1'b0;
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_beat(input in_beat_t bt, input bit chk = 1'b0,
                           input result_t want = '0);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push      <= 1'b1;
    in_beat_i <= bt;
    note_chk  = chk;
    note_want = want;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    if (bt.req_type != REQ_UNUSED) beats_sent++;
    @(negedge clk_i);
  endtask

  function automatic int msg_len(logic [7:0] t);
    case (t)
      CH_F, CH_A: return 36;
      CH_C, CH_E, CH_X: return 23;
      CH_D: return 19;
      CH_U: return 35;
      default: return $urandom_range(40, 1);
    endcase
  endfunction

  function automatic logic [7:0] read_code();
    if ($urandom_range(9) < 7) return TYPE_CODES[$urandom_range(6)];
    return 8'($urandom_range(255));
  endfunction

  task automatic send_message();
    logic [7:0] t, b;
    int         len, nominal, shape, fill, x;
    if ($urandom_range(99) < 90) t = TYPE_CODES[$urandom_range(6)];
    else t = 8'($urandom_range(255));
    nominal = msg_len(t);
    shape   = $urandom_range(99);
    if (shape < 70) len = nominal;
    else if (shape < 85) len = $urandom_range(nominal, 1);
    else len = $urandom_range(80, nominal);
    fill = $urandom_range(9);
    for (int i = 0; i < len; i++) begin
      if (i > 0) begin
        x = $urandom_range(99);
        if (x < 3) begin
          send_beat(beat(REQ_READ, read_code(), 1'($urandom_range(1))));
        end else if (x == 3) begin
          send_beat(beat(REQ_UNUSED, 8'($urandom_range(255)), 1'($urandom_range(1))));
        end else if (x == 4) begin
          // abandon the message midway
          send_beat(beat(REQ_EMPTY, 8'($urandom_range(255)), 1'($urandom_range(1))));
          return;
        end
      end
      case (fill)
        0: b = 8'hFF;
        1: b = 8'h00;
        default: begin
          x = $urandom_range(9);
          b = (x == 0) ? 8'h00 : (x == 1) ? 8'hFF : 8'($urandom_range(255));
        end
      endcase
      if (i == 0) b = t;
      if (i == 19 && $urandom_range(1)) b = CH_B;
      send_beat(beat(REQ_BYTE, b, i == len - 1));
    end
  endtask

  initial begin
    int base, n, pick;
    dir_tab = '{
      '{beat(REQ_READ, CH_F, 1'b0), 1'b1, res(ST_OK, KIND_ADD, 16'h0, 1'b0, 0)},
      '{beat(REQ_EMPTY, 8'h00, 1'b1), 1'b1, res(ST_EMPTY, KIND_ADD, 16'h0, 1'b0, 0)},
      '{beat(REQ_UNUSED, 8'hFF, 1'b1), 1'b0, '0},
      '{beat(REQ_BYTE, "Z", 1'b1), 1'b1, res(ST_UNKNOWN, KIND_ADD, 16'h0, 1'b0, 0)},
      // one-byte add: zero padded, so the side is not B
      '{beat(REQ_BYTE, CH_A, 1'b1), 1'b1, res(ST_OK, KIND_ADD, 16'h0, 1'b1, 1)},
      '{beat(REQ_BYTE, CH_D, 1'b1), 1'b1, res(ST_OK, KIND_DELETE, 16'h0, 1'b0, 2)},
      '{beat(REQ_READ, CH_A, 1'b1), 1'b1, res(ST_OK, KIND_ADD, 16'h0, 1'b0, 1)},
      '{beat(REQ_READ, 8'hFF, 1'b0), 1'b1, res(ST_OK, KIND_ADD, 16'h0, 1'b0, 0)},
      '{beat(REQ_BYTE, CH_X, 1'b0), 1'b0, '0},
      '{beat(REQ_BYTE, 8'h12, 1'b0), 1'b0, '0},
      '{beat(REQ_BYTE, 8'h34, 1'b0), 1'b0, '0},
      '{beat(REQ_EMPTY, 8'hFF, 1'b0), 1'b1, res(ST_EMPTY, KIND_ADD, 16'h0, 1'b0, 2)},
      '{beat(REQ_BYTE, CH_C, 1'b0), 1'b0, '0},
      '{beat(REQ_BYTE, 8'hFF, 1'b0), 1'b0, '0},
      // count read in the middle of a message leaves it intact
      '{beat(REQ_READ, CH_D, 1'b1), 1'b1, res(ST_OK, KIND_ADD, 16'h0, 1'b0, 1)},
      '{beat(REQ_BYTE, 8'hFF, 1'b0), 1'b0, '0},
      '{beat(REQ_BYTE, 8'h00, 1'b1), 1'b1, res(ST_OK, KIND_EXECUTE, 16'hFFFF, 1'b0, 3)},
      '{beat(REQ_BYTE, CH_U, 1'b0), 1'b0, '0},
      '{beat(REQ_BYTE, 8'h00, 1'b0), 1'b0, '0},
      '{beat(REQ_BYTE, 8'h01, 1'b1), 1'b1, res(ST_OK, KIND_REPLACE, 16'h0001, 1'b0, 4)},
      '{beat(REQ_BYTE, 8'h00, 1'b0), 1'b0, '0},
      '{beat(REQ_BYTE, 8'hFF, 1'b1), 1'b1, res(ST_UNKNOWN, KIND_ADD, 16'h0, 1'b0, 4)},
      '{beat(REQ_READ, CH_U, 1'b0), 1'b1, res(ST_OK, KIND_ADD, 16'h0, 1'b0, 1)},
      '{beat(REQ_READ, CH_X, 1'b1), 1'b1, res(ST_OK, KIND_ADD, 16'h0, 1'b0, 0)}
    };
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_idle_pct = 16;
    recv_idle_pct = 67;
    foreach (dir_tab[i]) send_beat(dir_tab[i].beat, dir_tab[i].chk, dir_tab[i].want);

    base = beats_sent;
    while (beats_sent - base < RAND_BEATS || results_made < MIN_RESULTS) begin
      n = beats_sent - base;
      if (n < 280) begin
        send_idle_pct = 16;
        recv_idle_pct = 67;
      end else if (n < 560) begin
        send_idle_pct = 67;
        recv_idle_pct = 16;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_go = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 82)
        send_message();
      else if (pick < 88)
        send_beat(beat(REQ_READ, read_code(), 1'($urandom_range(1))));
      else if (pick < 92)
        send_beat(beat(REQ_EMPTY, 8'($urandom_range(255)), 1'($urandom_range(1))));
      else
        send_beat(beat(2'($urandom_range(3)), 8'($urandom_range(255)),
                       1'($urandom_range(1))));
    end
    push <= 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;

    while (results_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && results_due.size() == 0)
      $display("tb_order_message_field_extractor: PASS");
    else
      $display("tb_order_message_field_extractor: FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/ome_pkg.sv
hdl/ome_front.sv
hdl/ome_queue.sv
hdl/ome_back.sv
hdl/order_message_field_extractor.sv
hdl/ome_checker.sv
test/tb_order_message_field_extractor.sv
